>>> hdl/piecewise_bezier_curve_eval_core_macros.svh
// ----------------------------------------------------------------------------
// piecewise bezier curve eval assertion macros
// shared concurrent assertion shorthands, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_BEZIER_CURVE_EVAL_CORE_MACROS_SVH
`define PIECEWISE_BEZIER_CURVE_EVAL_CORE_MACROS_SVH

// same-cycle implication
`define PBC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBC_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/pbce_pkg.sv
// ----------------------------------------------------------------------------
// pbce_pkg
// types and constants of the piecewise bezier curve evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbce_pkg;

   localparam int GRID_RES       = 4096;
   localparam int GRID_SHIFT     = $clog2(GRID_RES);
   localparam int MAX_POINTS_DEF = 64;
   localparam int BISECT_DEF     = 10;
   localparam int QDEPTH         = 2;
   localparam int VW             = 34;
   localparam int WW             = 29;
   localparam logic [6:0] POINTS_RESET = 7'd2;
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_SCAN,
      S_HANDLE,
      S_MUL,
      S_ADD,
      S_SCALE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic               mode;
      logic               ratio_ok;
      logic [5:0]         point_index;
      logic [12:0]        center_x;
      logic signed [15:0] center_y;
      logic [12:0]        left_x;
      logic signed [15:0] left_y;
      logic [12:0]        right_x;
      logic signed [15:0] right_y;
      logic signed [17:0] ratio;
      logic signed [31:0] start_value;
      logic signed [31:0] end_value;
   } entry_type;

endpackage

`default_nettype wire

>>> hdl/pbce_front.sv
// ----------------------------------------------------------------------------
// pbce_front
// accepts items, checks the ratio range and queues them for the engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_bezier_curve_eval_core_macros.svh"

module pbce_front
   import pbce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [5:0]         req_point_index,
   input  wire logic [12:0]        req_center_x,
   input  wire logic signed [15:0] req_center_y,
   input  wire logic [12:0]        req_left_x,
   input  wire logic signed [15:0] req_left_y,
   input  wire logic [12:0]        req_right_x,
   input  wire logic signed [15:0] req_right_y,
   input  wire logic signed [17:0] req_ratio,
   input  wire logic signed [31:0] req_start_value,
   input  wire logic signed [31:0] req_end_value,
   input  wire logic               pop,
   output logic                    head_valid,
   output entry_type               head
);

   entry_type  q_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   entry_type  entry;

   always_comb begin
      entry.mode        = req_mode;
      entry.ratio_ok    = !req_ratio[17] && (req_ratio <= 18'sd65536);
      entry.point_index = req_point_index;
      entry.center_x    = req_center_x;
      entry.center_y    = req_center_y;
      entry.left_x      = req_left_x;
      entry.left_y      = req_left_y;
      entry.right_x     = req_right_x;
      entry.right_y     = req_right_y;
      entry.ratio       = req_ratio;
      entry.start_value = req_start_value;
      entry.end_value   = req_end_value;
   end

   assign busy       = (count_ff == 2'(QDEPTH));
   assign push       = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   `PBC_ASSERT_IMP(a_pop_nonempty, pop, count_ff != 2'd0, "pop from empty queue")
   `PBC_ASSERT_IMP(a_count_max, 1'b1, count_ff <= 2'(QDEPTH), "queue count overflow")
   `PBC_ASSERT_NXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 2'd1, "count lost")

endmodule

`default_nettype wire

>>> hdl/pbce_back.sv
// ----------------------------------------------------------------------------
// pbce_back
// point table, segment scan, bisection on x(t), y(t) evaluation and scaling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_bezier_curve_eval_core_macros.svh"

module pbce_back
   import pbce_pkg::*;
#(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int BISECT_STEPS = BISECT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire entry_type          head,
   input  wire logic [6:0]         points_in_use,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_in_range
);

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int F   = BISECT_STEPS + 1;
   localparam int TW  = F + 1;
   localparam int SW  = $clog2(BISECT_STEPS + 1);
   localparam int PW  = VW + TW + 2;
   localparam int FW  = VW - GRID_SHIFT;
   localparam int SPW = FW + 33;
   localparam logic [2:0] LAST_LERP = 3'd5;
   localparam logic signed [39:0] SAT_HI = 40'sh007FFFFFFF;
   localparam logic signed [39:0] SAT_LO = -40'sh0080000000;

   function automatic logic signed [VW-1:0] pt_x(input logic [WW-1:0] w);
      return VW'({w[12:0], 16'b0});
   endfunction

   function automatic logic signed [VW-1:0] pt_y(input logic [WW-1:0] w);
      logic signed [31:0] v;
      v = {w[28:13], 16'b0};
      return VW'(v);
   endfunction

   logic [WW-1:0] cen_mem [MAX_POINTS];
   logic [WW-1:0] lft_mem [MAX_POINTS];
   logic [WW-1:0] rgt_mem [MAX_POINTS];
   logic [WW-1:0] rd_c_ff, rd_l_ff, rd_r_ff;
   logic [AW-1:0] c_addr, l_addr, r_addr, w_addr;
   logic          mem_we;

   state_type               state_ff, state_in;
   entry_type               item_ff, item_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [WW-1:0]           prev_ff, prev_in;
   logic [WW-1:0]           cur_ff, cur_in;
   logic signed [VW-1:0]    target_ff, target_in;
   logic signed [VW-1:0]    cx_ff [4];
   logic signed [VW-1:0]    cx_in [4];
   logic signed [VW-1:0]    cy_ff [4];
   logic signed [VW-1:0]    cy_in [4];
   logic signed [VW-1:0]    l_ff [5];
   logic signed [VW-1:0]    l_in [5];
   logic [2:0]              k_ff, k_in;
   logic                    phase_y_ff, phase_y_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [TW-1:0]           tl_ff, tl_in, tr_ff, tr_in, ta_ff, ta_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [VW-1:0]    base_ff, base_in;
   logic signed [VW-1:0]    yv_ff, yv_in;
   logic signed [SPW-1:0]   sprod_ff, sprod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_in_range_ff, rsp_in_range_in;

   logic [CW-1:0]           n_eff;
   logic signed [VW-1:0]    p [4];
   logic signed [VW-1:0]    opa, opb, res;
   logic signed [VW:0]      diff;
   logic signed [VW-1:0]    xp, xc;
   logic [TW-1:0]           tl_n, tr_n;
   logic signed [FW-1:0]    fy;
   logic signed [32:0]      span;
   logic signed [39:0]      vsum;

   assign n_eff = (32'(points_in_use) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(points_in_use);
   assign xp    = pt_x(prev_ff);
   assign xc    = pt_x(rd_c_ff);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p[i] = phase_y_ff ? cy_ff[i] : cx_ff[i];
      end
      case (k_ff)
         3'd0: begin opa = p[0];    opb = p[1];    end
         3'd1: begin opa = p[1];    opb = p[2];    end
         3'd2: begin opa = p[2];    opb = p[3];    end
         3'd3: begin opa = l_ff[0]; opb = l_ff[1]; end
         3'd4: begin opa = l_ff[1]; opb = l_ff[2]; end
         default: begin opa = l_ff[3]; opb = l_ff[4]; end
      endcase
      diff = {opb[VW-1], opb} - {opa[VW-1], opa};
      res  = base_ff + VW'(prod_ff >>> F);
      fy   = FW'(yv_ff >>> GRID_SHIFT);
      span = 33'(item_ff.end_value) - 33'(item_ff.start_value);
      vsum = 40'(item_ff.start_value) + 40'(sprod_ff >>> 16);
   end

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      idx_in          = idx_ff;
      prev_in         = prev_ff;
      cur_in          = cur_ff;
      target_in       = target_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      l_in            = l_ff;
      k_in            = k_ff;
      phase_y_in      = phase_y_ff;
      step_in         = step_ff;
      tl_in           = tl_ff;
      tr_in           = tr_ff;
      ta_in           = ta_ff;
      prod_in         = prod_ff;
      base_in         = base_ff;
      yv_in           = yv_ff;
      sprod_in        = sprod_ff;
      rsp_valid_in    = 1'b0;
      rsp_value_in    = rsp_value_ff;
      rsp_in_range_in = rsp_in_range_ff;
      pop             = 1'b0;
      mem_we          = 1'b0;
      w_addr          = AW'(head.point_index);
      c_addr          = '0;
      l_addr          = idx_ff;
      r_addr          = idx_ff - 1'b1;
      tl_n            = tl_ff;
      tr_n            = tr_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               item_in = head;
               if (head.mode == MODE_WRITE) begin
                  mem_we = (32'(head.point_index) < MAX_POINTS);
               end else if (!head.ratio_ok || n_eff < CW'(2)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_value_in    = '0;
                  rsp_in_range_in = 1'b0;
               end else begin
                  target_in = VW'({head.ratio[16:0], {GRID_SHIFT{1'b0}}});
                  state_in  = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            prev_in  = rd_c_ff;
            idx_in   = AW'(1);
            c_addr   = AW'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            c_addr = idx_ff + 1'b1;
            if (xp <= target_ff && target_ff <= xc) begin
               cur_in   = rd_c_ff;
               state_in = S_HANDLE;
            end else if (32'(idx_ff) + 1 == 32'(n_eff)) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = '0;
               rsp_in_range_in = 1'b0;
               state_in        = S_IDLE;
            end else begin
               prev_in = rd_c_ff;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_HANDLE: begin
            cx_in[0]   = pt_x(prev_ff);
            cx_in[1]   = pt_x(rd_r_ff);
            cx_in[2]   = pt_x(rd_l_ff);
            cx_in[3]   = pt_x(cur_ff);
            cy_in[0]   = pt_y(prev_ff);
            cy_in[1]   = pt_y(rd_r_ff);
            cy_in[2]   = pt_y(rd_l_ff);
            cy_in[3]   = pt_y(cur_ff);
            tl_in      = '0;
            tr_in      = TW'(1) << F;
            ta_in      = TW'(1) << (F - 1);
            k_in       = '0;
            step_in    = '0;
            phase_y_in = 1'b0;
            state_in   = S_MUL;
         end
         S_MUL: begin
            prod_in  = diff * $signed({1'b0, ta_ff});
            base_in  = opa;
            state_in = S_ADD;
         end
         S_ADD: begin
            if (k_ff != LAST_LERP) begin
               l_in[k_ff] = res;
               k_in       = k_ff + 3'd1;
               state_in   = S_MUL;
            end else if (phase_y_ff) begin
               yv_in    = res;
               state_in = S_SCALE;
            end else begin
               if (target_ff < res) begin
                  tr_n = ta_ff;
               end else begin
                  tl_n = ta_ff;
               end
               tl_in = tl_n;
               tr_in = tr_n;
               ta_in = TW'(({1'b0, tl_n} + {1'b0, tr_n}) >> 1);
               k_in  = '0;
               if (32'(step_ff) == BISECT_STEPS - 1) begin
                  phase_y_in = 1'b1;
               end else begin
                  step_in = step_ff + 1'b1;
               end
               state_in = S_MUL;
            end
         end
         S_SCALE: begin
            sprod_in = fy * span;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in    = 1'b1;
            rsp_in_range_in = 1'b1;
            if (vsum > SAT_HI) begin
               rsp_value_in = 32'sh7FFFFFFF;
            end else if (vsum < SAT_LO) begin
               rsp_value_in = 32'sh80000000;
            end else begin
               rsp_value_in = 32'(vsum);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      idx_ff          <= idx_in;
      prev_ff         <= prev_in;
      cur_ff          <= cur_in;
      target_ff       <= target_in;
      cx_ff           <= cx_in;
      cy_ff           <= cy_in;
      l_ff            <= l_in;
      k_ff            <= k_in;
      phase_y_ff      <= phase_y_in;
      step_ff         <= step_in;
      tl_ff           <= tl_in;
      tr_ff           <= tr_in;
      ta_ff           <= ta_in;
      prod_ff         <= prod_in;
      base_ff         <= base_in;
      yv_ff           <= yv_in;
      sprod_ff        <= sprod_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_in_range_ff <= rsp_in_range_in;
   end

   // point table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cen_mem[w_addr] <= {head.center_y, head.center_x};
         lft_mem[w_addr] <= {head.left_y, head.left_x};
         rgt_mem[w_addr] <= {head.right_y, head.right_x};
      end
      rd_c_ff <= cen_mem[c_addr];
      rd_l_ff <= lft_mem[l_addr];
      rd_r_ff <= rgt_mem[r_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_in_range = rsp_in_range_ff;

   `PBC_ASSERT_IMP(a_miss_zero, rsp_valid_ff && !rsp_in_range_ff, rsp_value_ff == '0, "miss not zero")
   `PBC_ASSERT_IMP(a_pop_idle, pop, state_ff == S_IDLE, "pop outside idle")
   `PBC_ASSERT_NXT(a_handle_bez, state_ff == S_HANDLE, state_ff == S_MUL && k_ff == '0, "bad start")

endmodule

`default_nettype wire

>>> hdl/piecewise_bezier_curve_eval_core.sv
// ----------------------------------------------------------------------------
// piecewise_bezier_curve_eval_core
// piecewise cubic bezier easing curve evaluator with a point table
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue lets
// up to two items wait while the engine works. A point write gives no result.
// An evaluation scans the segments up to the bracketing one, bisects on x(t)
// and then evaluates y(t); each curve point takes six lerps through the single
// shared lerp multiplier, each lerp passing through S_MUL and then S_ADD. Each
// result is shown on rsp_value / rsp_in_range for one cycle with rsp_valid
// high and the receiver cannot stall it. Table slots read before being
// written give undefined results.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_bezier_curve_eval_core
   import pbce_pkg::*;
#(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int BISECT_STEPS = BISECT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [5:0]         req_point_index,
   input  wire logic [12:0]        req_center_x,
   input  wire logic signed [15:0] req_center_y,
   input  wire logic [12:0]        req_left_x,
   input  wire logic signed [15:0] req_left_y,
   input  wire logic [12:0]        req_right_x,
   input  wire logic signed [15:0] req_right_y,
   input  wire logic signed [17:0] req_ratio,
   input  wire logic signed [31:0] req_start_value,
   input  wire logic signed [31:0] req_end_value,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_in_range,
   input  wire logic               csr_we,
   input  wire logic [6:0]         csr_wdata
);

   logic [6:0] points_in_use_ff;
   logic       pop;
   logic       head_valid;
   entry_type  head;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= POINTS_RESET;
      end else if (csr_we) begin
         points_in_use_ff <= csr_wdata;
      end
   end

   pbce_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_point_index (req_point_index),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .req_ratio       (req_ratio),
      .req_start_value (req_start_value),
      .req_end_value   (req_end_value),
      .pop             (pop),
      .head_valid      (head_valid),
      .head            (head)
   );

   pbce_back #(
      .MAX_POINTS   (MAX_POINTS),
      .BISECT_STEPS (BISECT_STEPS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .points_in_use (points_in_use_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_in_range  (rsp_in_range)
   );

endmodule

`default_nettype wire
